// ===== rtl/flhc_pkg.sv =====
// shared types, codes and constants of the fpga link handshake controller
package flhc_pkg;

  localparam int WORD_BITS = 16;
  localparam int MS_BITS   = 16;
  localparam int RETRY_BITS = 8;
  localparam int POS_BITS  = 3;
  localparam int FUNC_BITS = 2;
  localparam int CMD_BITS  = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [MS_BITS-1:0]    RESET_PULSE_DEF = MS_BITS'(10);
  localparam logic [MS_BITS-1:0]    POLL_DEF        = MS_BITS'(10);
  localparam logic [MS_BITS-1:0]    ACK_WAIT_DEF    = MS_BITS'(10);
  localparam logic [RETRY_BITS-1:0] RETRIES_DEF     = RETRY_BITS'(10);
  localparam logic [POS_BITS-1:0]   BUSY_POS_DEF    = POS_BITS'(0);
  localparam logic [POS_BITS-1:0]   RO_POS_DEF      = POS_BITS'(1);

  typedef enum logic [2:0] {
    PH_RESET = 3'd0,
    PH_WAIT  = 3'd1,
    PH_ACK   = 3'd2,
    PH_CHECK = 3'd3,
    PH_FREE  = 3'd4,
    PH_WRITE = 3'd5,
    PH_ERROR = 3'd6
  } phase_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_XFER  = 2'd2
  } spi_cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RESET_PULSE = 3'd0,
    REG_POLL        = 3'd1,
    REG_ACK_WAIT    = 3'd2,
    REG_RETRIES     = 3'd3,
    REG_BUSY_POS    = 3'd4,
    REG_RO_POS      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [MS_BITS-1:0]    reset_pulse_ms;
    logic [MS_BITS-1:0]    poll_interval_ms;
    logic [MS_BITS-1:0]    ack_wait_ms;
    logic [RETRY_BITS-1:0] max_retries;
    logic [POS_BITS-1:0]   busy_bit_pos;
    logic [POS_BITS-1:0]   read_only_bit_pos;
  } cfg_regs_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [WORD_BITS-1:0] data_word;
    logic                 ms_tick;
    logic                 spi_idle;
    logic                 bus_held_other;
    logic [WORD_BITS-1:0] rx_word;
  } in_item_t;

  typedef struct packed {
    phase_t                phase;
    logic [MS_BITS-1:0]    ms_count;
    logic [RETRY_BITS-1:0] retry_count;
    logic [WORD_BITS-1:0]  tx_buffer;
    logic [WORD_BITS-1:0]  rx_buffer;
    logic                  write_pending;
    logic                  ready_flag;
    logic                  bus_held;
    logic                  select_n;
    logic                  reset_line;
    logic                  gen_on;
    logic                  wait_after_write;
  } link_state_t;

  typedef struct packed {
    logic                 chip_select_n;
    logic                 fpga_reset;
    logic                 clock_gen_on;
    spi_cmd_t             spi_cmd;
    logic [WORD_BITS-1:0] tx_word;
    logic                 bus_claim;
    logic                 link_ready;
    logic [WORD_BITS-1:0] last_rx;
    phase_t               phase;
    logic                 reset_notice;
    logic                 error_event;
  } out_item_t;

endpackage

// ===== rtl/flhc_in_if.sv =====
// input transaction channel of the link controller
interface flhc_in_if;
  logic                           valid;
  logic                           ready;
  logic [flhc_pkg::FUNC_BITS-1:0] func;
  logic [flhc_pkg::WORD_BITS-1:0] data_word;
  logic                           ms_tick;
  logic                           spi_idle;
  logic                           bus_held_other;
  logic [flhc_pkg::WORD_BITS-1:0] rx_word;

  modport source (output valid, func, data_word, ms_tick, spi_idle, bus_held_other, rx_word,
                  input ready);
  modport sink (input valid, func, data_word, ms_tick, spi_idle, bus_held_other, rx_word,
                output ready);
endinterface

// ===== rtl/flhc_out_if.sv =====
// result transaction channel of the link controller
interface flhc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           chip_select_n;
  logic                           fpga_reset;
  logic                           clock_gen_on;
  logic [flhc_pkg::CMD_BITS-1:0]  spi_cmd;
  logic [flhc_pkg::WORD_BITS-1:0] tx_word;
  logic                           bus_claim;
  logic                           link_ready;
  logic [flhc_pkg::WORD_BITS-1:0] last_rx;
  logic [2:0]                     phase;
  logic                           reset_notice;
  logic                           error_event;

  modport source (output valid, chip_select_n, fpga_reset, clock_gen_on, spi_cmd, tx_word,
                  bus_claim, link_ready, last_rx, phase, reset_notice, error_event,
                  input ready);
  modport sink (input valid, chip_select_n, fpga_reset, clock_gen_on, spi_cmd, tx_word,
                bus_claim, link_ready, last_rx, phase, reset_notice, error_event,
                output ready);
endinterface

// ===== rtl/flhc_cfg_if.sv =====
// configuration write channel of the link controller
interface flhc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [flhc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [flhc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/flhc_step.sv =====
// link state machine: next state and result for one transaction
module flhc_step (
  input  flhc_pkg::cfg_regs_t   cfg,
  input  flhc_pkg::link_state_t st,
  input  flhc_pkg::in_item_t    item,
  output flhc_pkg::link_state_t st_nxt,
  output flhc_pkg::out_item_t   res
);

  logic [flhc_pkg::MS_BITS-1:0] ms_inc;
  logic [flhc_pkg::MS_BITS-1:0] wait_len;
  logic                         is_step;
  logic                         reset_done;
  logic                         wait_done;
  logic                         ack_go;
  logic                         busy;
  logic                         retry_ok;
  logic                         write_go;
  flhc_pkg::phase_t             phase_nxt;
  flhc_pkg::func_t              func;

  assign func       = flhc_pkg::func_t'(item.func);
  assign ms_inc     = (item.ms_tick && (st.ms_count != '1)) ?
                      st.ms_count + flhc_pkg::MS_BITS'(1) : st.ms_count;
  assign wait_len   = st.wait_after_write ? cfg.ack_wait_ms : cfg.poll_interval_ms;
  assign is_step    = (func == flhc_pkg::FUNC_STEP) || (func == flhc_pkg::FUNC_SPARE);
  assign reset_done = ms_inc >= cfg.reset_pulse_ms;
  assign wait_done  = ms_inc >= wait_len;
  assign ack_go     = !item.bus_held_other && item.spi_idle;
  assign busy       = item.rx_word[cfg.busy_bit_pos];
  assign retry_ok   = st.retry_count < cfg.max_retries;
  assign write_go   = st.write_pending && !item.bus_held_other && item.spi_idle;

  // next phase
  always_comb begin
    phase_nxt = st.phase;
    if (func == flhc_pkg::FUNC_RESET) begin
      phase_nxt = flhc_pkg::PH_RESET;
    end else if (is_step) begin
      unique case (st.phase)
        flhc_pkg::PH_RESET: if (reset_done) phase_nxt = flhc_pkg::PH_WAIT;
        flhc_pkg::PH_WRITE: if (item.spi_idle) phase_nxt = flhc_pkg::PH_WAIT;
        flhc_pkg::PH_WAIT:  if (wait_done) phase_nxt = flhc_pkg::PH_ACK;
        flhc_pkg::PH_ACK:   if (ack_go) phase_nxt = flhc_pkg::PH_CHECK;
        flhc_pkg::PH_CHECK: begin
          if (item.spi_idle) begin
            if (!busy) phase_nxt = flhc_pkg::PH_FREE;
            else if (retry_ok) phase_nxt = flhc_pkg::PH_WAIT;
            else phase_nxt = flhc_pkg::PH_ERROR;
          end
        end
        flhc_pkg::PH_FREE:  if (write_go) phase_nxt = flhc_pkg::PH_WRITE;
        default:            phase_nxt = flhc_pkg::PH_RESET;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    logic link_rst;
    link_rst = 1'b0;
    st_nxt = st;
    st_nxt.ms_count = ms_inc;
    st_nxt.phase = phase_nxt;
    res = '0;
    res.spi_cmd = flhc_pkg::CMD_NONE;

    if (func == flhc_pkg::FUNC_WRITE) begin
      st_nxt.tx_buffer     = item.data_word;
      st_nxt.write_pending = 1'b1;
      st_nxt.ready_flag    = 1'b0;
    end else if (func == flhc_pkg::FUNC_RESET) begin
      link_rst = 1'b1;
    end else begin
      unique case (st.phase)
        flhc_pkg::PH_RESET: begin
          if (reset_done) begin
            st_nxt.reset_line       = 1'b0;
            st_nxt.wait_after_write = 1'b0;
            st_nxt.ms_count         = '0;
          end
        end
        flhc_pkg::PH_WRITE: begin
          if (item.spi_idle) begin
            st_nxt.select_n         = 1'b1;
            st_nxt.bus_held         = 1'b0;
            st_nxt.wait_after_write = 1'b1;
            st_nxt.ms_count         = '0;
          end
        end
        flhc_pkg::PH_WAIT: ;
        flhc_pkg::PH_ACK: begin
          if (ack_go) begin
            st_nxt.bus_held = 1'b1;
            st_nxt.select_n = 1'b0;
            res.spi_cmd     = flhc_pkg::CMD_XFER;
            res.tx_word     = flhc_pkg::WORD_BITS'(1) << cfg.read_only_bit_pos;
          end
        end
        flhc_pkg::PH_CHECK: begin
          if (item.spi_idle) begin
            st_nxt.select_n  = 1'b1;
            st_nxt.bus_held  = 1'b0;
            st_nxt.rx_buffer = item.rx_word;
            if (!busy) begin
              st_nxt.gen_on     = 1'b0;
              st_nxt.ready_flag = 1'b1;
            end else if (retry_ok) begin
              st_nxt.retry_count      = st.retry_count + flhc_pkg::RETRY_BITS'(1);
              st_nxt.wait_after_write = 1'b0;
              st_nxt.ms_count         = '0;
            end else begin
              st_nxt.retry_count = '0;
              res.error_event    = 1'b1;
            end
          end
        end
        flhc_pkg::PH_FREE: begin
          if (write_go) begin
            st_nxt.write_pending = 1'b0;
            st_nxt.gen_on        = 1'b1;
            st_nxt.bus_held      = 1'b1;
            st_nxt.select_n      = 1'b0;
            st_nxt.retry_count   = '0;
            res.spi_cmd          = flhc_pkg::CMD_WRITE;
            res.tx_word          = st.tx_buffer;
          end
        end
        default: link_rst = 1'b1;
      endcase
    end

    // link reset keeps the retry count
    if (link_rst) begin
      res.reset_notice        = 1'b1;
      st_nxt.bus_held         = 1'b0;
      st_nxt.ready_flag       = 1'b0;
      st_nxt.write_pending    = 1'b0;
      st_nxt.tx_buffer        = '0;
      st_nxt.rx_buffer        = '0;
      st_nxt.gen_on           = 1'b1;
      st_nxt.select_n         = 1'b1;
      st_nxt.reset_line       = 1'b1;
      st_nxt.wait_after_write = 1'b0;
      st_nxt.ms_count         = '0;
    end

    res.chip_select_n = st_nxt.select_n;
    res.fpga_reset    = st_nxt.reset_line;
    res.clock_gen_on  = st_nxt.gen_on;
    res.bus_claim     = st_nxt.bus_held;
    res.link_ready    = st_nxt.ready_flag;
    res.last_rx       = st_nxt.rx_buffer;
    res.phase         = st_nxt.phase;
  end

endmodule

// ===== rtl/fpga_link_handshake_controller.sv =====
// top level of the fpga link handshake controller
//
// in_if carries one transaction per event: a time step, a queued data write
// or a reset request, together with the ms tick and the spi engine and bus
// status sampled for that event. out_if returns exactly one result per input
// transaction with the pin levels, the spi command to start, the link status
// and the reset and error pulses. cfg_if writes the six timing, retry and bit
// position registers; it is always ready, and the user must use it only while
// the block is idle, which the block itself does not enforce. a transaction is
// captured in the input register and evaluated by the state machine into the
// result register. one transaction is taken every cycle while out_if drains.
// if the receiver stalls, the held result waits in the result register and
// one more transaction is taken into the input register before in_if.ready
// drops. reset clears both stages, loads the register defaults, asserts the
// fpga reset line, starts the clock generator and enters the reset phase.
module fpga_link_handshake_controller (
  input logic          clk,
  input logic          rst_n,
  flhc_in_if.sink      in_if,
  flhc_out_if.source   out_if,
  flhc_cfg_if.sink     cfg_if
);

  flhc_pkg::cfg_regs_t   cfg_r;
  flhc_pkg::link_state_t st_r;
  flhc_pkg::link_state_t st_nxt;
  flhc_pkg::in_item_t    in_r;
  flhc_pkg::out_item_t   out_r;
  flhc_pkg::out_item_t   res_nxt;
  logic                  in_valid_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_take;
  logic                  cfg_take;

  assign advance  = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take  = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_take = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_pulse_ms    <= flhc_pkg::RESET_PULSE_DEF;
      cfg_r.poll_interval_ms  <= flhc_pkg::POLL_DEF;
      cfg_r.ack_wait_ms       <= flhc_pkg::ACK_WAIT_DEF;
      cfg_r.max_retries       <= flhc_pkg::RETRIES_DEF;
      cfg_r.busy_bit_pos      <= flhc_pkg::BUSY_POS_DEF;
      cfg_r.read_only_bit_pos <= flhc_pkg::RO_POS_DEF;
    end else if (cfg_take) begin
      unique case (cfg_if.index)
        flhc_pkg::REG_RESET_PULSE:
          cfg_r.reset_pulse_ms <= cfg_if.data[flhc_pkg::MS_BITS-1:0];
        flhc_pkg::REG_POLL:
          cfg_r.poll_interval_ms <= cfg_if.data[flhc_pkg::MS_BITS-1:0];
        flhc_pkg::REG_ACK_WAIT:
          cfg_r.ack_wait_ms <= cfg_if.data[flhc_pkg::MS_BITS-1:0];
        flhc_pkg::REG_RETRIES:
          cfg_r.max_retries <= cfg_if.data[flhc_pkg::RETRY_BITS-1:0];
        flhc_pkg::REG_BUSY_POS:
          cfg_r.busy_bit_pos <= cfg_if.data[flhc_pkg::POS_BITS-1:0];
        flhc_pkg::REG_RO_POS:
          cfg_r.read_only_bit_pos <= cfg_if.data[flhc_pkg::POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.func           <= in_if.func;
      in_r.data_word      <= in_if.data_word;
      in_r.ms_tick        <= in_if.ms_tick;
      in_r.spi_idle       <= in_if.spi_idle;
      in_r.bus_held_other <= in_if.bus_held_other;
      in_r.rx_word        <= in_if.rx_word;
    end
  end

  flhc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase            <= flhc_pkg::PH_RESET;
      st_r.ms_count         <= '0;
      st_r.retry_count      <= '0;
      st_r.tx_buffer        <= '0;
      st_r.rx_buffer        <= '0;
      st_r.write_pending    <= 1'b0;
      st_r.ready_flag       <= 1'b0;
      st_r.bus_held         <= 1'b0;
      st_r.select_n         <= 1'b1;
      st_r.reset_line       <= 1'b1;
      st_r.gen_on           <= 1'b1;
      st_r.wait_after_write <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.chip_select_n = out_r.chip_select_n;
  assign out_if.fpga_reset    = out_r.fpga_reset;
  assign out_if.clock_gen_on  = out_r.clock_gen_on;
  assign out_if.spi_cmd       = out_r.spi_cmd;
  assign out_if.tx_word       = out_r.tx_word;
  assign out_if.bus_claim     = out_r.bus_claim;
  assign out_if.link_ready    = out_r.link_ready;
  assign out_if.last_rx       = out_r.last_rx;
  assign out_if.phase         = out_r.phase;
  assign out_if.reset_notice  = out_r.reset_notice;
  assign out_if.error_event   = out_r.error_event;

endmodule

// ===== tb/tb_fpga_link_handshake_controller.sv =====
// self-checking testbench of the fpga link handshake controller with a cycle-free link predictor
module tb_fpga_link_handshake_controller;
  import flhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_ROWS       = 22;
  localparam int PHASES         = 6;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t NO_TYPED = '0;

  logic clk;
  logic rst_n;

  flhc_in_if  in_if();
  flhc_out_if out_if();
  flhc_cfg_if cfg_if();

  fpga_link_handshake_controller uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  cfg_regs_t   link_cfg;
  link_state_t link_st;
  out_item_t   link_results[$];
  int          failures;
  int          idle_cycles;
  int          no_gap_left;
  int          ready_left;
  logic        ready_level;
  dir_row_t    dir_rows [DIR_ROWS];

  function automatic void restart_link();
    link_st.bus_held         = 1'b0;
    link_st.ready_flag       = 1'b0;
    link_st.write_pending    = 1'b0;
    link_st.tx_buffer        = '0;
    link_st.rx_buffer        = '0;
    link_st.gen_on           = 1'b1;
    link_st.select_n         = 1'b1;
    link_st.reset_line       = 1'b1;
    link_st.wait_after_write = 1'b0;
    link_st.ms_count         = '0;
    link_st.phase            = PH_RESET;
  endfunction

  function automatic out_item_t predict_link(input in_item_t it);
    out_item_t r;
    logic [MS_BITS-1:0] wait_ms;
    r = NO_TYPED;
    r.spi_cmd = CMD_NONE;
    if (it.ms_tick && link_st.ms_count != {MS_BITS{1'b1}})
      link_st.ms_count = link_st.ms_count + 1'b1;
    case (it.func)
      FUNC_WRITE: begin
        link_st.tx_buffer     = it.data_word;
        link_st.write_pending = 1'b1;
        link_st.ready_flag    = 1'b0;
      end
      FUNC_RESET: begin
        r.reset_notice = 1'b1;
        restart_link();
      end
      default: begin
        case (link_st.phase)
          PH_RESET: begin
            if (link_st.ms_count >= link_cfg.reset_pulse_ms) begin
              link_st.reset_line       = 1'b0;
              link_st.wait_after_write = 1'b0;
              link_st.ms_count         = '0;
              link_st.phase            = PH_WAIT;
            end
          end
          PH_WRITE: begin
            if (it.spi_idle) begin
              link_st.select_n         = 1'b1;
              link_st.bus_held         = 1'b0;
              link_st.wait_after_write = 1'b1;
              link_st.ms_count         = '0;
              link_st.phase            = PH_WAIT;
            end
          end
          PH_WAIT: begin
            wait_ms = link_st.wait_after_write ? link_cfg.ack_wait_ms : link_cfg.poll_interval_ms;
            if (link_st.ms_count >= wait_ms)
              link_st.phase = PH_ACK;
          end
          PH_ACK: begin
            if (!it.bus_held_other && it.spi_idle) begin
              link_st.bus_held = 1'b1;
              link_st.select_n = 1'b0;
              r.spi_cmd        = CMD_XFER;
              r.tx_word        = WORD_BITS'(1) << link_cfg.read_only_bit_pos;
              link_st.phase    = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (it.spi_idle) begin
              link_st.select_n  = 1'b1;
              link_st.bus_held  = 1'b0;
              link_st.rx_buffer = it.rx_word;
              if (!it.rx_word[link_cfg.busy_bit_pos]) begin
                link_st.gen_on     = 1'b0;
                link_st.ready_flag = 1'b1;
                link_st.phase      = PH_FREE;
              end else if (link_st.retry_count < link_cfg.max_retries) begin
                link_st.retry_count      = link_st.retry_count + 1'b1;
                link_st.wait_after_write = 1'b0;
                link_st.ms_count         = '0;
                link_st.phase            = PH_WAIT;
              end else begin
                link_st.retry_count = '0;
                r.error_event       = 1'b1;
                link_st.phase       = PH_ERROR;
              end
            end
          end
          PH_FREE: begin
            if (link_st.write_pending && !it.bus_held_other && it.spi_idle) begin
              link_st.write_pending = 1'b0;
              link_st.gen_on        = 1'b1;
              link_st.bus_held      = 1'b1;
              link_st.select_n      = 1'b0;
              r.spi_cmd             = CMD_WRITE;
              r.tx_word             = link_st.tx_buffer;
              link_st.retry_count   = '0;
              link_st.phase         = PH_WRITE;
            end
          end
          default: begin
            r.reset_notice = 1'b1;
            restart_link();
          end
        endcase
      end
    endcase
    r.chip_select_n = link_st.select_n;
    r.fpga_reset    = link_st.reset_line;
    r.clock_gen_on  = link_st.gen_on;
    r.bus_claim     = link_st.bus_held;
    r.link_ready    = link_st.ready_flag;
    r.last_rx       = link_st.rx_buffer;
    r.phase         = link_st.phase;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) it.func = FUNC_STEP;
    else if (r < 92) it.func = FUNC_WRITE;
    else if (r < 96) it.func = FUNC_SPARE;
    else it.func = FUNC_RESET;
    r = $urandom_range(0, 19);
    if (r == 0) it.data_word = '0;
    else if (r == 1) it.data_word = '1;
    else it.data_word = WORD_BITS'($urandom);
    it.ms_tick        = 1'($urandom_range(0, 1));
    it.spi_idle       = ($urandom_range(0, 99) < 80);
    it.bus_held_other = ($urandom_range(0, 99) < 25);
    it.rx_word        = WORD_BITS'($urandom);
    return it;
  endfunction

  function automatic cfg_regs_t random_cfg();
    cfg_regs_t c;
    c.reset_pulse_ms    = MS_BITS'($urandom_range(1, 3));
    c.poll_interval_ms  = MS_BITS'($urandom_range(1, 3));
    c.ack_wait_ms       = MS_BITS'($urandom_range(1, 3));
    c.max_retries       = RETRY_BITS'($urandom_range(0, 3));
    c.busy_bit_pos      = POS_BITS'($urandom_range(0, 7));
    c.read_only_bit_pos = POS_BITS'($urandom_range(0, 7));
    return c;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_RESET_PULSE: link_cfg.reset_pulse_ms    = value;
      REG_POLL:        link_cfg.poll_interval_ms  = value;
      REG_ACK_WAIT:    link_cfg.ack_wait_ms       = value;
      REG_RETRIES:     link_cfg.max_retries       = value[RETRY_BITS-1:0];
      REG_BUSY_POS:    link_cfg.busy_bit_pos      = value[POS_BITS-1:0];
      default:         link_cfg.read_only_bit_pos = value[POS_BITS-1:0];
    endcase
  endtask

  task automatic load_config(input cfg_regs_t c);
    write_reg(REG_RESET_PULSE, c.reset_pulse_ms);
    write_reg(REG_POLL, c.poll_interval_ms);
    write_reg(REG_ACK_WAIT, c.ack_wait_ms);
    write_reg(REG_RETRIES, CFG_DATA_BITS'(c.max_retries));
    write_reg(REG_BUSY_POS, CFG_DATA_BITS'(c.busy_bit_pos));
    write_reg(REG_RO_POS, CFG_DATA_BITS'(c.read_only_bit_pos));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_item(input in_item_t it, input int gap, input logic typed,
                           input out_item_t want);
    out_item_t pred;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= it.func;
    in_if.data_word      <= it.data_word;
    in_if.ms_tick        <= it.ms_tick;
    in_if.spi_idle       <= it.spi_idle;
    in_if.bus_held_other <= it.bus_held_other;
    in_if.rx_word        <= it.rx_word;
    do @(posedge clk); while (!in_if.ready);
    pred = predict_link(it);
    link_results.insert(link_results.size(), typed ? want : pred);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (link_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [WORD_BITS-1:0] want,
                                      input logic [WORD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      failures++;
    end
  endfunction

  // result side: checks each accepted transaction and stalls at random
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (link_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        failures++;
      end else begin
        want = link_results.pop_front();
        check_field("chip_select_n", WORD_BITS'(want.chip_select_n), WORD_BITS'(out_if.chip_select_n));
        check_field("fpga_reset", WORD_BITS'(want.fpga_reset), WORD_BITS'(out_if.fpga_reset));
        check_field("clock_gen_on", WORD_BITS'(want.clock_gen_on), WORD_BITS'(out_if.clock_gen_on));
        check_field("spi_cmd", WORD_BITS'(want.spi_cmd), WORD_BITS'(out_if.spi_cmd));
        check_field("tx_word", want.tx_word, out_if.tx_word);
        check_field("bus_claim", WORD_BITS'(want.bus_claim), WORD_BITS'(out_if.bus_claim));
        check_field("link_ready", WORD_BITS'(want.link_ready), WORD_BITS'(out_if.link_ready));
        check_field("last_rx", want.last_rx, out_if.last_rx);
        check_field("phase", WORD_BITS'(want.phase), WORD_BITS'(out_if.phase));
        check_field("reset_notice", WORD_BITS'(want.reset_notice), WORD_BITS'(out_if.reset_notice));
        check_field("error_event", WORD_BITS'(want.error_event), WORD_BITS'(out_if.error_event));
      end
    end
    if (ready_left > 0) begin
      ready_left--;
    end else if (!ready_level || $urandom_range(0, 99) < 40) begin
      ready_level = 1'b1;
      ready_left  = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 150) : $urandom_range(1, 25);
    end else begin
      ready_level = 1'b0;
      ready_left  = ($urandom_range(0, 99) < 6) ? $urandom_range(20, 40) : $urandom_range(0, 2);
    end
    out_if.ready <= rst_n ? ready_level : 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_regs_t c;
    int n_items;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.func           = FUNC_STEP;
    in_if.data_word      = '0;
    in_if.ms_tick        = 1'b0;
    in_if.spi_idle       = 1'b0;
    in_if.bus_held_other = 1'b0;
    in_if.rx_word        = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_RESET_PULSE;
    cfg_if.data          = '0;
    failures             = 0;
    no_gap_left          = 0;
    ready_left           = 0;
    ready_level          = 1'b0;
    link_cfg = '{RESET_PULSE_DEF, POLL_DEF, ACK_WAIT_DEF, RETRIES_DEF, BUSY_POS_DEF, RO_POS_DEF};
    link_st.retry_count = '0;
    restart_link();

    // directed rows assume pulse 1, poll 1, ack 2, no retries, busy bit 7, status bit 0
    dir_rows = '{
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000}, 1'b1,
        out_item_t'{1'b1, 1'b1, 1'b1, CMD_NONE, 16'h0000, 1'b0, 1'b0, 16'h0000,
                    PH_RESET, 1'b0, 1'b0}},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b1, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0080}, 1'b1,
        out_item_t'{1'b1, 1'b0, 1'b1, CMD_NONE, 16'h0000, 1'b0, 1'b0, 16'h0080,
                    PH_ERROR, 1'b0, 1'b1}},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000}, 1'b1,
        out_item_t'{1'b1, 1'b1, 1'b1, CMD_NONE, 16'h0000, 1'b0, 1'b0, 16'h0000,
                    PH_RESET, 1'b1, 1'b0}},
      '{in_item_t'{FUNC_WRITE, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'hFF7F}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_SPARE, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_STEP, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_WRITE, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_WRITE, 16'hA5A5, 1'b0, 1'b1, 1'b0, 16'h0000}, 1'b0, NO_TYPED},
      '{in_item_t'{FUNC_RESET, 16'h0000, 1'b1, 1'b1, 1'b0, 16'hFFFF}, 1'b1,
        out_item_t'{1'b1, 1'b1, 1'b1, CMD_NONE, 16'h0000, 1'b0, 1'b0, 16'h0000,
                    PH_RESET, 1'b1, 1'b0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    load_config('{16'd1, 16'd1, 16'd2, 8'd0, 3'd7, 3'd0});
    foreach (dir_rows[i])
      send_item(dir_rows[i].stim, pick_gap(), dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: begin
          c = '{16'd1, 16'd1, 16'd1, 8'd255, 3'd0, 3'd7};
          n_items = 300;
        end
        2: begin
          c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 3'd7, 3'd0};
          n_items = 60;
        end
        default: begin
          c = random_cfg();
          n_items = 340;
        end
      endcase
      load_config(c);
      repeat (n_items) send_item(random_item(), pick_gap(), 1'b0, NO_TYPED);
    end

    settle();
    if (failures == 0 && link_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
